// ===== hdl/ppmcd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ppmcd_pkg
// Shared types, constants and a helper function of the PPM channel decoder.
// ============================================================================
package ppmcd_pkg;

    localparam int CHANNELS = 8;
    localparam int CNT_W    = $clog2(CHANNELS + 1);
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TIME_W   = 32;
    localparam int WIDTH_W  = 16;
    localparam int CH_W     = 3;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH    = 2'd2;

    localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST = 16'd3000;
    localparam logic [CFG_W-1:0] MIN_WIDTH_RST    = 16'd900;
    localparam logic [CFG_W-1:0] MAX_WIDTH_RST    = 16'd2100;

    typedef struct packed {
        logic [CFG_W-1:0] idle_timeout;
        logic [CFG_W-1:0] min_width;
        logic [CFG_W-1:0] max_width;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] edge_time;
        logic              level;
    } edge_t;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [WIDTH_W-1:0] filtered_width;
    } result_t;

    function automatic logic [WIDTH_W-1:0] median3(
        input logic [WIDTH_W-1:0] a,
        input logic [WIDTH_W-1:0] b,
        input logic [WIDTH_W-1:0] c
    );
        logic [WIDTH_W-1:0] lo;
        logic [WIDTH_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) begin
            return lo;
        end else if (c >= hi) begin
            return hi;
        end
        return c;
    endfunction

endpackage

// ===== hdl/ppmcd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ppmcd_cfg_regs
// Configuration registers: idle timeout and pulse width clamp limits.
// ============================================================================
module ppmcd_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ppmcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppmcd_pkg::CFG_W-1:0]     cfg_data,
    output ppmcd_pkg::cfg_t                cfg
);

    ppmcd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_timeout <= ppmcd_pkg::IDLE_TIMEOUT_RST;
            cfg_reg.min_width    <= ppmcd_pkg::MIN_WIDTH_RST;
            cfg_reg.max_width    <= ppmcd_pkg::MAX_WIDTH_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ppmcd_pkg::REG_IDLE_TIMEOUT: cfg_reg.idle_timeout <= cfg_data;
                ppmcd_pkg::REG_MIN_WIDTH:    cfg_reg.min_width    <= cfg_data;
                ppmcd_pkg::REG_MAX_WIDTH:    cfg_reg.max_width    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/ppmcd_in_reg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ppmcd_in_reg
// Input register: captures one edge item and holds it until the decoder
// takes it.
// ============================================================================
module ppmcd_in_reg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ppmcd_pkg::TIME_W-1:0] s_edge_time,
    input  logic                        s_level,
    input  logic                        pop,
    output logic                        item_valid,
    output ppmcd_pkg::edge_t            item
);

    logic             valid_reg;
    ppmcd_pkg::edge_t item_reg;

    assign s_ready = !valid_reg || pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.edge_time <= s_edge_time;
            item_reg.level     <= s_level;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/ppmcd_decode.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ppmcd_decode
// Frame tracking, width measurement and clamp, per-channel median filter.
// Updates decoder state only when it takes an item.
// ============================================================================
module ppmcd_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  ppmcd_pkg::cfg_t     cfg,
    input  logic                item_valid,
    input  ppmcd_pkg::edge_t    item,
    input  logic                out_space,
    output logic                pop,
    output logic                res_load,
    output ppmcd_pkg::result_t  res
);

    localparam int CNT_W   = ppmcd_pkg::CNT_W;
    localparam int IDX_W   = ppmcd_pkg::IDX_W;
    localparam int TIME_W  = ppmcd_pkg::TIME_W;
    localparam int WIDTH_W = ppmcd_pkg::WIDTH_W;
    localparam int CHANNELS = ppmcd_pkg::CHANNELS;

    logic [TIME_W-1:0]  last_edge_time_reg;
    logic [TIME_W-1:0]  rise_time_reg;
    logic [CNT_W-1:0]   next_channel_reg;
    logic [WIDTH_W-1:0] hist_newer_reg [CHANNELS];
    logic [WIDTH_W-1:0] hist_older_reg [CHANNELS];

    logic [TIME_W-1:0]  gap;
    logic               timeout;
    logic [CNT_W-1:0]   cur_channel;
    logic               in_frame;
    logic               produce;
    logic [IDX_W-1:0]   idx;
    logic [TIME_W-1:0]  raw_width;
    logic [WIDTH_W-1:0] clamped;
    logic [WIDTH_W-1:0] newer;
    logic [WIDTH_W-1:0] older;
    logic [CNT_W-1:0]   next_channel_next;

    always_comb begin
        gap         = item.edge_time - last_edge_time_reg;
        timeout     = gap > {{(TIME_W-WIDTH_W){1'b0}}, cfg.idle_timeout};
        cur_channel = timeout ? '0 : next_channel_reg;
        in_frame    = cur_channel < CNT_W'(CHANNELS);
        produce     = !item.level && in_frame;
        idx         = cur_channel[IDX_W-1:0];
        raw_width   = item.edge_time - rise_time_reg;
        if (raw_width > {{(TIME_W-WIDTH_W){1'b0}}, cfg.max_width}) begin
            clamped = cfg.max_width;
        end else if (raw_width < {{(TIME_W-WIDTH_W){1'b0}}, cfg.min_width}) begin
            clamped = cfg.min_width;
        end else begin
            clamped = raw_width[WIDTH_W-1:0];
        end
        newer = hist_newer_reg[idx];
        older = hist_older_reg[idx];
        next_channel_next = produce ? cur_channel + CNT_W'(1) : cur_channel;
    end

    assign pop      = item_valid && out_space;
    assign res_load = pop && produce;
    assign res.channel        = ppmcd_pkg::CH_W'(cur_channel);
    assign res.filtered_width = ppmcd_pkg::median3(clamped, newer, older);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_edge_time_reg <= '0;
            rise_time_reg      <= '0;
            next_channel_reg   <= CNT_W'(CHANNELS);
            for (int i = 0; i < CHANNELS; i++) begin
                hist_newer_reg[i] <= '0;
                hist_older_reg[i] <= '0;
            end
        end else if (pop) begin
            last_edge_time_reg <= item.edge_time;
            next_channel_reg   <= next_channel_next;
            if (item.level) begin
                rise_time_reg <= item.edge_time;
            end
            if (produce) begin
                hist_older_reg[idx] <= newer;
                hist_newer_reg[idx] <= clamped;
            end
        end
    end

endmodule

// ===== hdl/ppmcd_out_reg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ppmcd_out_reg
// Result register: holds one decoded item until the receiver takes it.
// ============================================================================
module ppmcd_out_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          res_load,
    input  ppmcd_pkg::result_t            res,
    output logic                          out_space,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ppmcd_pkg::CH_W-1:0]    m_channel,
    output logic [ppmcd_pkg::WIDTH_W-1:0] m_filtered_width
);

    logic               valid_reg;
    ppmcd_pkg::result_t res_reg;

    assign out_space = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

    assign m_valid          = valid_reg;
    assign m_channel        = res_reg.channel;
    assign m_filtered_width = res_reg.filtered_width;

endmodule

// ===== hdl/ppm_channel_decoder_median.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ppm_channel_decoder_median
// PPM receiver decoder with a per-channel 3-tap median filter.
// ============================================================================
// Input channel (s_): one item per line edge, its microsecond timestamp and
// the pin level after the edge. Result channel (m_): channel index and the
// median-filtered pulse width, one item per decoded falling edge; rising
// edges, edges outside a frame and edges past the last channel give none.
// Configuration: cfg_we/cfg_index/cfg_data write idle timeout (0), min width
// (1) and max width (2); other indexes are ignored. Write only while idle.
// Path: an accepted edge is held in the input register until the result
// register has space; a decoded result is then loaded there and m_valid rises.
// Throughput: one item per cycle when not stalled; state (frame counter, last
// edge and rise times, width history) updates in the cycle it takes an item.
// Reset: clears state; no frame is open until a gap above the idle timeout.
// Stall: while m_ready is low the result register holds; one more edge waits
// in the input register, after which s_ready drops.
// ============================================================================
module ppm_channel_decoder_median (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ppmcd_pkg::TIME_W-1:0]      s_edge_time,
    input  logic                              s_level,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ppmcd_pkg::CH_W-1:0]        m_channel,
    output logic [ppmcd_pkg::WIDTH_W-1:0]     m_filtered_width,
    input  logic                              cfg_we,
    input  logic [ppmcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppmcd_pkg::CFG_W-1:0]       cfg_data
);

    ppmcd_pkg::cfg_t    cfg;
    ppmcd_pkg::edge_t   item;
    ppmcd_pkg::result_t res;
    logic               item_valid;
    logic               pop;
    logic               res_load;
    logic               out_space;

    ppmcd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppmcd_in_reg u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_edge_time (s_edge_time),
        .s_level     (s_level),
        .pop         (pop),
        .item_valid  (item_valid),
        .item        (item)
    );

    ppmcd_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .out_space  (out_space),
        .pop        (pop),
        .res_load   (res_load),
        .res        (res)
    );

    ppmcd_out_reg u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .res_load         (res_load),
        .res              (res),
        .out_space        (out_space),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_channel        (m_channel),
        .m_filtered_width (m_filtered_width)
    );

endmodule

// ===== hdl/ppmcd_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ppmcd_checker
// Port-level checks of the PPM channel decoder, bound to the top level.
// ============================================================================
module ppmcd_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_ready,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [ppmcd_pkg::CH_W-1:0]    m_channel,
    input  logic [ppmcd_pkg::WIDTH_W-1:0] m_filtered_width
);

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_channel)
            && $stable(m_filtered_width))
        else $error("result item changed while stalled");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a stalled result");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_two_cycle_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $past(aresetn) && $past(aresetn, 2))
        else $error("result appeared too soon after reset");

endmodule

bind ppm_channel_decoder_median ppmcd_checker u_ppmcd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_channel        (m_channel),
    .m_filtered_width (m_filtered_width)
);

// ===== verif/ppm_channel_decoder_median_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ppm_channel_decoder_median_checker
// Watches the edge, result and configuration ports of the PPM decoder,
// predicts the decoded channel widths and compares them in order.
// ============================================================================
module ppm_channel_decoder_median_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [ppmcd_pkg::TIME_W-1:0]    s_edge_time,
    input  logic                            s_level,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [ppmcd_pkg::CH_W-1:0]      m_channel,
    input  logic [ppmcd_pkg::WIDTH_W-1:0]   m_filtered_width,
    input  logic                            cfg_we,
    input  logic [ppmcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppmcd_pkg::CFG_W-1:0]     cfg_data,
    output int                              fail_count,
    output int                              pending
);

    ppmcd_pkg::cfg_t               cfg;
    logic [ppmcd_pkg::TIME_W-1:0]  prev_edge;
    logic [ppmcd_pkg::TIME_W-1:0]  pulse_start;
    int unsigned                   frame_ch;
    logic [ppmcd_pkg::WIDTH_W-1:0] hist_newer [ppmcd_pkg::CHANNELS];
    logic [ppmcd_pkg::WIDTH_W-1:0] hist_older [ppmcd_pkg::CHANNELS];
    ppmcd_pkg::result_t            decoded_q [$];

    function automatic logic [ppmcd_pkg::WIDTH_W-1:0] middle_of(
        input logic [ppmcd_pkg::WIDTH_W-1:0] a,
        input logic [ppmcd_pkg::WIDTH_W-1:0] b,
        input logic [ppmcd_pkg::WIDTH_W-1:0] c
    );
        logic [ppmcd_pkg::WIDTH_W-1:0] lo;
        logic [ppmcd_pkg::WIDTH_W-1:0] hi;
        logic [ppmcd_pkg::WIDTH_W-1:0] capped;
        lo     = (a < b) ? a : b;
        hi     = (a < b) ? b : a;
        capped = (c < hi) ? c : hi;
        return (capped > lo) ? capped : lo;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: decoder mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic decode_edge(input logic [ppmcd_pkg::TIME_W-1:0] t, input logic lvl);
        logic [ppmcd_pkg::TIME_W-1:0]  gap;
        logic [ppmcd_pkg::TIME_W-1:0]  width;
        logic [ppmcd_pkg::WIDTH_W-1:0] clamped;
        int unsigned                   ch;
        ppmcd_pkg::result_t            res;
        gap = t - prev_edge;
        if (gap > {16'd0, cfg.idle_timeout}) begin
            frame_ch = 0;
        end
        if (lvl) begin
            pulse_start = t;
        end else if (frame_ch < ppmcd_pkg::CHANNELS) begin
            ch    = frame_ch;
            width = t - pulse_start;
            if (width > {16'd0, cfg.max_width}) begin
                clamped = cfg.max_width;
            end else if (width < {16'd0, cfg.min_width}) begin
                clamped = cfg.min_width;
            end else begin
                clamped = width[ppmcd_pkg::WIDTH_W-1:0];
            end
            res.channel        = ch[ppmcd_pkg::CH_W-1:0];
            res.filtered_width = middle_of(clamped, hist_newer[ch], hist_older[ch]);
            hist_older[ch]     = hist_newer[ch];
            hist_newer[ch]     = clamped;
            decoded_q.push_back(res);
            frame_ch = ch + 1;
        end
        prev_edge = t;
    endtask

    always @(posedge aclk) begin
        ppmcd_pkg::result_t want;
        if (!aresetn) begin
            fail_count       = 0;
            cfg.idle_timeout = ppmcd_pkg::IDLE_TIMEOUT_RST;
            cfg.min_width    = ppmcd_pkg::MIN_WIDTH_RST;
            cfg.max_width    = ppmcd_pkg::MAX_WIDTH_RST;
            prev_edge        = '0;
            pulse_start      = '0;
            frame_ch         = ppmcd_pkg::CHANNELS;
            for (int i = 0; i < ppmcd_pkg::CHANNELS; i++) begin
                hist_newer[i] = '0;
                hist_older[i] = '0;
            end
            decoded_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    ppmcd_pkg::REG_IDLE_TIMEOUT: cfg.idle_timeout = cfg_data;
                    ppmcd_pkg::REG_MIN_WIDTH:    cfg.min_width    = cfg_data;
                    ppmcd_pkg::REG_MAX_WIDTH:    cfg.max_width    = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                decode_edge(s_edge_time, s_level);
            end
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item ch=%0d width=%0d",
                                              m_channel, m_filtered_width));
                end else begin
                    want = decoded_q.pop_front();
                    if (m_channel !== want.channel ||
                        m_filtered_width !== want.filtered_width) begin
                        report_mismatch($sformatf("ch=%0d width=%0d, want ch=%0d width=%0d",
                                                  m_channel, m_filtered_width,
                                                  want.channel, want.filtered_width));
                    end
                end
            end
        end
        pending <= decoded_q.size();
    end

endmodule

// ===== verif/ppm_channel_decoder_median_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ppm_channel_decoder_median_tb
// Drives edge items into the PPM decoder under several register settings and
// flow-control patterns; the checker predicts and compares every result.
// ============================================================================
module ppm_channel_decoder_median_tb;

    localparam logic [ppmcd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 90;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            s_valid     = 1'b0;
    logic                            s_ready;
    logic [ppmcd_pkg::TIME_W-1:0]    s_edge_time = '0;
    logic                            s_level     = 1'b0;
    logic                            m_valid;
    logic                            m_ready     = 1'b0;
    logic [ppmcd_pkg::CH_W-1:0]      m_channel;
    logic [ppmcd_pkg::WIDTH_W-1:0]   m_filtered_width;
    logic                            cfg_we      = 1'b0;
    logic [ppmcd_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [ppmcd_pkg::CFG_W-1:0]     cfg_data    = '0;

    int                              fail_count;
    int                              pending;

    int unsigned                     tx_idle_pct  = 0;
    int unsigned                     rx_stall_pct = 0;
    bit                              rx_hold      = 1'b0;
    event                            hold_off_ev;
    int unsigned                     items_sent   = 0;
    logic [ppmcd_pkg::TIME_W-1:0]    now_t        = '0;
    int unsigned                     cur_idle     = 32'(ppmcd_pkg::IDLE_TIMEOUT_RST);
    int unsigned                     cur_min      = 32'(ppmcd_pkg::MIN_WIDTH_RST);
    int unsigned                     cur_max      = 32'(ppmcd_pkg::MAX_WIDTH_RST);

    ppm_channel_decoder_median dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_edge_time      (s_edge_time),
        .s_level          (s_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_channel        (m_channel),
        .m_filtered_width (m_filtered_width),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    ppm_channel_decoder_median_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_edge_time      (s_edge_time),
        .s_level          (s_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_channel        (m_channel),
        .m_filtered_width (m_filtered_width),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (rx_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        forever begin
            @(hold_off_ev);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            rx_hold = 1'b0;
        end
    end

    initial begin
        #5ms;
        $display("ppm_channel_decoder_median_tb: FAIL");
        $finish;
    end

    task automatic send_edge(input logic [ppmcd_pkg::TIME_W-1:0] t, input logic lvl);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid     <= 1'b1;
        s_edge_time <= t;
        s_level     <= lvl;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_config(input logic [ppmcd_pkg::CFG_W-1:0] idle,
                                input logic [ppmcd_pkg::CFG_W-1:0] lo,
                                input logic [ppmcd_pkg::CFG_W-1:0] hi);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= ppmcd_pkg::REG_IDLE_TIMEOUT;
        cfg_data  <= idle;
        @(posedge aclk);
        cfg_index <= ppmcd_pkg::REG_MIN_WIDTH;
        cfg_data  <= lo;
        @(posedge aclk);
        cfg_index <= ppmcd_pkg::REG_MAX_WIDTH;
        cfg_data  <= hi;
        @(posedge aclk);
        cfg_index <= REG_SPARE;
        cfg_data  <= ppmcd_pkg::CFG_W'($urandom);
        @(posedge aclk);
        cfg_we   <= 1'b0;
        cur_idle = 32'(idle);
        cur_min  = 32'(lo);
        cur_max  = 32'(hi);
    endtask

    function automatic logic [ppmcd_pkg::TIME_W-1:0] pick_width();
        case ($urandom_range(9))
            5:       return $urandom_range(cur_min);
            6:       return cur_max + $urandom_range(1000);
            7:       return $urandom_range(1) ? cur_min : cur_max;
            8:       return $urandom_range(65535);
            9:       return $urandom;
            default: return $urandom_range(cur_max, cur_min);
        endcase
    endfunction

    function automatic logic [ppmcd_pkg::TIME_W-1:0] frame_gap();
        case ($urandom_range(7))
            0:       return cur_idle;
            1:       return cur_idle + 1;
            default: return $urandom_range(cur_idle < 1000 ? cur_idle : 1000);
        endcase
    endfunction

    function automatic logic [ppmcd_pkg::TIME_W-1:0] sync_gap();
        if ($urandom_range(3) == 0) begin
            return $urandom;
        end
        return cur_idle + 1 + $urandom_range(500);
    endfunction

    task automatic send_pulse(input logic [ppmcd_pkg::TIME_W-1:0] gap,
                              input logic [ppmcd_pkg::TIME_W-1:0] width);
        now_t += gap;
        if ($urandom_range(15) != 0) begin
            send_edge(now_t, 1'b1);
        end
        now_t += width;
        send_edge(now_t, 1'b0);
    endtask

    task automatic send_frame();
        int unsigned pulses;
        pulses = $urandom_range(ppmcd_pkg::CHANNELS + 2, 1);
        send_pulse(sync_gap(), pick_width());
        for (int i = 1; i < pulses; i++) begin
            send_pulse(frame_gap(), pick_width());
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(4, 1)) begin
            case ($urandom_range(2))
                0:       now_t = $urandom;
                1:       now_t += $urandom_range(65535);
                default: ;
            endcase
            send_edge(now_t, 1'($urandom_range(1)));
        end
    endtask

    task automatic run_phase(input int unsigned count);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(9) < 8) begin
                send_frame();
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin
        logic [ppmcd_pkg::TIME_W-1:0] widths [8];
        widths = '{900, 2100, 899, 2101, 0, 1234, 2999, 1800};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: no frame yet, then clamps, fall without rise, wrap
        send_edge(32'd100, 1'b0);
        send_edge(32'd5000, 1'b1);
        send_edge(32'd5500, 1'b0);
        send_edge(32'd6000, 1'b1);
        send_edge(32'd8500, 1'b0);
        send_edge(32'd9000, 1'b0);
        send_edge(32'd12000, 1'b1);
        send_edge(32'd13500, 1'b0);
        send_edge(32'hFFFF_FC00, 1'b1);
        send_edge(32'h0000_0200, 1'b0);
        send_edge(32'hFFFF_FFFF, 1'b1);
        send_edge(32'h0000_0000, 1'b0);
        now_t = '0;
        // run past the last channel
        foreach (widths[i]) begin
            now_t += 100;
            send_edge(now_t, 1'b1);
            now_t += widths[i];
            send_edge(now_t, 1'b0);
        end

        write_config(ppmcd_pkg::IDLE_TIMEOUT_RST, ppmcd_pkg::MIN_WIDTH_RST,
                     ppmcd_pkg::MAX_WIDTH_RST);
        run_phase(PHASE_ITEMS);

        write_config(16'hFFFF, 16'h0000, 16'hFFFF);
        tx_idle_pct = 85;
        run_phase(PHASE_ITEMS);

        write_config(16'd0, 16'd1000, 16'd2000);
        tx_idle_pct  = 0;
        rx_stall_pct = 85;
        run_phase(PHASE_ITEMS);

        write_config(16'd5000, 16'd2000, 16'd1000);
        tx_idle_pct  = 20;
        rx_stall_pct = 20;
        run_phase(PHASE_ITEMS / 2);
        drain_results();
        run_phase(PHASE_ITEMS / 2);

        write_config(ppmcd_pkg::CFG_W'($urandom_range(20000, 1000)),
                     ppmcd_pkg::CFG_W'($urandom_range(65535)),
                     ppmcd_pkg::CFG_W'($urandom_range(65535)));
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        -> hold_off_ev;
        run_phase(PHASE_ITEMS);

        write_config(16'd1, 16'hFFFF, 16'h0000);
        tx_idle_pct  = 20;
        rx_stall_pct = 20;
        run_phase(PHASE_ITEMS);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ppm_channel_decoder_median_tb: PASS");
        end else begin
            $display("ppm_channel_decoder_median_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== ppm_channel_decoder_median.f =====
hdl/ppmcd_pkg.sv
hdl/ppmcd_cfg_regs.sv
hdl/ppmcd_in_reg.sv
hdl/ppmcd_decode.sv
hdl/ppmcd_out_reg.sv
hdl/ppm_channel_decoder_median.sv
hdl/ppmcd_checker.sv
verif/ppm_channel_decoder_median_checker.sv
verif/ppm_channel_decoder_median_tb.sv
